// ===== design/pmeq_pkg.sv =====
// ----------------------------------------------------------------------------
// pmeq_pkg
// Shared constants, word types and codes for the priority masked event queue.
// ----------------------------------------------------------------------------
package pmeq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CODE_BITS   = 8;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int ENTRY_W     = CODE_BITS + 2;

  typedef enum logic [1:0] {
    CMD_ENQ   = 2'd0,
    CMD_DEQ   = 2'd1,
    CMD_PURGE = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    PRIO_LOW      = 2'd0,
    PRIO_NORMAL   = 2'd1,
    PRIO_CRITICAL = 2'd2,
    PRIO_SYNC     = 2'd3
  } prio_e;

  typedef enum logic [1:0] {
    STS_OK   = 2'd0,
    STS_FULL = 2'd1,
    STS_NONE = 2'd2,
    STS_RSVD = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] event_code;
    logic [1:0] event_prio;
    logic       critical_only;
    logic       low_ok;
  } pmeq_in_t;

  typedef struct packed {
    logic       found;
    logic [7:0] out_code;
    logic [1:0] out_priority;
    logic [1:0] status;
    logic [3:0] removed_count;
    logic [3:0] occupancy;
  } pmeq_out_t;

  typedef struct packed {
    logic [CODE_BITS-1:0] code;
    logic [1:0]           prio;
  } entry_t;

  function automatic logic [CODE_BITS-1:0] code_from_field(logic [7:0] c);
    logic [CODE_BITS+7:0] w;
    w = {{CODE_BITS{1'b0}}, c};
    return w[CODE_BITS-1:0];
  endfunction

  function automatic logic [7:0] code_to_field(logic [CODE_BITS-1:0] c);
    logic [CODE_BITS+7:0] w;
    w = {8'd0, c};
    return w[7:0];
  endfunction

  function automatic logic [3:0] count_to_field(logic [PTR_W-1:0] v);
    logic [PTR_W+3:0] w;
    w = {4'd0, v};
    return w[3:0];
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] occ_count(logic [PTR_W-1:0] head,
                                                 logic [PTR_W-1:0] tail);
    logic [PTR_W:0] diff;
    if (tail >= head) begin
      diff = {1'b0, tail} - {1'b0, head};
    end else begin
      diff = {1'b0, tail} + (PTR_W+1)'(QUEUE_DEPTH) - {1'b0, head};
    end
    return diff[PTR_W-1:0];
  endfunction

endpackage

// ===== design/priority_masked_event_queue.sv =====
// ----------------------------------------------------------------------------
// priority_masked_event_queue
// Event queue with enqueue, eligible dequeue and purge, one result word per
// command word.
// ----------------------------------------------------------------------------
// The queue holds up to QUEUE_DEPTH-1 events in a single RAM and takes one
// command word at a time; in_stall_o stays high until that command's result
// has moved into the output register, and the next command word can be taken
// at the edge after that. Enqueue and the unused command code register
// their result in the controller and then pass it to the output register.
// Dequeue and purge sweep every occupied entry through the one RAM read
// port and write survivors back in order. A stalled output register holds
// the result and keeps in_stall_o high. A finished result waits in the
// output register while the next command word is already taken.
module priority_masked_event_queue
  import pmeq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  pmeq_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output pmeq_out_t out_data_o
);

  logic             busy;
  logic             res_valid;
  logic             res_take;
  pmeq_out_t        res;
  logic             ram_we;
  logic [PTR_W-1:0] ram_waddr;
  logic [PTR_W-1:0] ram_raddr;
  entry_t           ram_wdata;
  entry_t           ram_rdata;
  logic             out_valid_q, out_valid_d;
  pmeq_out_t        out_data_q, out_data_d;

  pmeq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_i       (in_data_i),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_take_i  (res_take),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  pmeq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o = busy;
  assign res_take   = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (res_valid && res_take) begin
      out_valid_d = 1'b1;
      out_data_d  = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== design/pmeq_ram.sv =====
// ----------------------------------------------------------------------------
// pmeq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pmeq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/pmeq_ctrl.sv =====
// ----------------------------------------------------------------------------
// pmeq_ctrl
// Command sequencer: enqueue at the tail, or sweep the occupied entries once
// through the RAM read port and rewrite the survivors in order (dequeue drops
// the first eligible entry, purge drops every matching one; any other command only reports occupancy).
// ----------------------------------------------------------------------------
module pmeq_ctrl
  import pmeq_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  input  pmeq_in_t         req_i,
  output logic             busy_o,
  output logic             res_valid_o,
  output pmeq_out_t        res_o,
  input  logic             res_take_i,
  output logic             ram_we_o,
  output logic [PTR_W-1:0] ram_waddr_o,
  output entry_t           ram_wdata_o,
  output logic [PTR_W-1:0] ram_raddr_o,
  input  entry_t           ram_rdata_i
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e           state_q, state_d;
  logic [PTR_W-1:0] head_q, tail_q, tail_d;
  logic [PTR_W-1:0] rd_q, rd_d, wr_q, wr_d;
  logic [PTR_W-1:0] removed_q, removed_d;
  logic             pend_q, pend_d;
  logic             taken_q, taken_d;
  logic [1:0]       cmd_q, cmd_d;
  entry_t           key_q, key_d;
  logic             crit_q, crit_d;
  logic             low_q, low_d;
  entry_t           hit_q, hit_d;
  pmeq_out_t        res_q, res_d;
  logic             eligible;
  logic             drop;

  always_comb begin
    case (ram_rdata_i.prio)
      PRIO_CRITICAL: eligible = 1'b1;
      PRIO_NORMAL:   eligible = !crit_q;
      PRIO_LOW:      eligible = low_q;
      default:       eligible = 1'b0;
    endcase
    if (cmd_q == CMD_PURGE) begin
      drop = (ram_rdata_i == key_q);
    end else begin
      drop = eligible && !taken_q;
    end
  end

  always_comb begin
    state_d     = state_q;
    tail_d      = tail_q;
    rd_d        = rd_q;
    wr_d        = wr_q;
    removed_d   = removed_q;
    pend_d      = 1'b0;
    taken_d     = taken_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    crit_d      = crit_q;
    low_d       = low_q;
    hit_d       = hit_q;
    res_d       = res_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = wr_q;
    ram_wdata_o = ram_rdata_i;

    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          cmd_d      = req_i.cmd;
          key_d.code = code_from_field(req_i.event_code);
          key_d.prio = req_i.event_prio;
          crit_d     = req_i.critical_only;
          low_d      = req_i.low_ok;
          rd_d       = head_q;
          wr_d       = head_q;
          removed_d  = '0;
          taken_d    = 1'b0;
          hit_d      = '0;
          res_d      = '0;
          res_d.status    = STS_OK;
          res_d.occupancy = count_to_field(occ_count(head_q, tail_q));
          case (req_i.cmd)
            CMD_ENQ: begin
              if (ptr_inc(tail_q) == head_q) begin
                res_d.status = STS_FULL;
              end else begin
                ram_we_o         = 1'b1;
                ram_waddr_o      = tail_q;
                ram_wdata_o.code = code_from_field(req_i.event_code);
                ram_wdata_o.prio = req_i.event_prio;
                tail_d           = ptr_inc(tail_q);
                res_d.occupancy  = count_to_field(occ_count(head_q, ptr_inc(tail_q)));
              end
              state_d = ST_DONE;
            end
            CMD_DEQ, CMD_PURGE: begin
              state_d = ST_SCAN;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (rd_q != tail_q) begin
          pend_d = 1'b1;
          rd_d   = ptr_inc(rd_q);
        end
        if (pend_q) begin
          if (drop) begin
            removed_d = removed_q + PTR_W'(1);
            if (!taken_q) begin
              hit_d = ram_rdata_i;
            end
            taken_d = 1'b1;
          end else begin
            ram_we_o = 1'b1;
            wr_d     = ptr_inc(wr_q);
          end
        end else if (rd_q == tail_q) begin
          tail_d          = wr_q;
          res_d.occupancy = count_to_field(occ_count(head_q, wr_q));
          if (cmd_q == CMD_PURGE) begin
            res_d.removed_count = count_to_field(removed_q);
          end else begin
            res_d.found        = taken_q;
            res_d.out_code     = code_to_field(hit_q.code);
            res_d.out_priority = hit_q.prio;
            res_d.status       = taken_q ? STS_OK : STS_NONE;
          end
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      head_q    <= '0;
      tail_q    <= '0;
      rd_q      <= '0;
      wr_q      <= '0;
      removed_q <= '0;
      pend_q    <= 1'b0;
      taken_q   <= 1'b0;
      cmd_q     <= CMD_NOP;
    end else begin
      state_q   <= state_d;
      tail_q    <= tail_d;
      rd_q      <= rd_d;
      wr_q      <= wr_d;
      removed_q <= removed_d;
      pend_q    <= pend_d;
      taken_q   <= taken_d;
      cmd_q     <= cmd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    crit_q <= crit_d;
    low_q  <= low_d;
    hit_q  <= hit_d;
    res_q  <= res_d;
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = res_q;
  assign ram_raddr_o = rd_q;

endmodule

// ===== dv/priority_masked_event_queue_test.sv =====
// ----------------------------------------------------------------------------
// priority_masked_event_queue_test
// Self-checking bench for the priority masked event queue. A behavioral copy
// of the queue predicts one result word per command word; results are
// compared field by field in order, under random idle cycles on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module priority_masked_event_queue_test;
  import pmeq_pkg::*;

  class event_queue_model;
    entry_t    held_events[$];
    pmeq_out_t expected_words[$];
    int        failures;
    int        words_checked;

    function void note_command(pmeq_in_t w);
      pmeq_out_t r;
      entry_t    e;
      int        hit;
      int        i;
      bit        ok;
      r   = '0;
      hit = -1;
      case (cmd_e'(w.cmd))
        CMD_ENQ: begin
          if (held_events.size() == QUEUE_DEPTH - 1) begin
            r.status = STS_FULL;
          end else begin
            e.code = w.event_code;
            e.prio = w.event_prio;
            held_events.push_back(e);
          end
        end
        CMD_DEQ: begin
          for (i = 0; i < held_events.size() && hit < 0; i++) begin
            case (prio_e'(held_events[i].prio))
              PRIO_CRITICAL: ok = 1'b1;
              PRIO_NORMAL:   ok = !w.critical_only;
              PRIO_LOW:      ok = w.low_ok;
              default:       ok = 1'b0;
            endcase
            if (ok) hit = i;
          end
          if (hit < 0) begin
            r.status = STS_NONE;
          end else begin
            r.found        = 1'b1;
            r.out_code     = held_events[hit].code;
            r.out_priority = held_events[hit].prio;
            held_events.delete(hit);
          end
        end
        CMD_PURGE: begin
          for (i = held_events.size() - 1; i >= 0; i--) begin
            if (held_events[i].code == w.event_code &&
                held_events[i].prio == w.event_prio) begin
              held_events.delete(i);
              r.removed_count = r.removed_count + 4'd1;
            end
          end
        end
        default: ;
      endcase
      r.occupancy = 4'(held_events.size());
      expected_words.push_back(r);
    endfunction

    function void check_word(pmeq_out_t got);
      pmeq_out_t want;
      if (expected_words.size() == 0) begin
        failures++;
        if (failures <= 10) $display("unexpected result word %h", got);
        return;
      end
      want = expected_words.pop_front();
      if (got.found !== want.found || got.out_code !== want.out_code ||
          got.out_priority !== want.out_priority || got.status !== want.status ||
          got.removed_count !== want.removed_count ||
          got.occupancy !== want.occupancy) begin
        failures++;
        if (failures <= 10) begin
          $display("word %0d: expected found=%0d code=%02h prio=%0d sts=%0d rm=%0d occ=%0d",
                   words_checked, want.found, want.out_code, want.out_priority,
                   want.status, want.removed_count, want.occupancy);
          $display("word %0d: actual   found=%0d code=%02h prio=%0d sts=%0d rm=%0d occ=%0d",
                   words_checked, got.found, got.out_code, got.out_priority,
                   got.status, got.removed_count, got.occupancy);
        end
      end
      words_checked++;
    endfunction
  endclass

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  pmeq_in_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  pmeq_out_t out_data_o;

  event_queue_model tracker = new();
  bit               steady_run = 1'b0;
  logic [7:0]       code_pool [4] = '{8'h00, 8'hFF, 8'h3C, 8'hC3};

  priority_masked_event_queue uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic send_word(input pmeq_in_t w);
    int gap;
    gap = steady_run ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    tracker.note_command(w);
  endtask

  task automatic issue(input cmd_e c, input logic [7:0] code, input prio_e p,
                       input bit crit_only, input bit low_ok);
    pmeq_in_t w;
    w.cmd           = c;
    w.event_code    = code;
    w.event_prio    = p;
    w.critical_only = crit_only;
    w.low_ok        = low_ok;
    send_word(w);
  endtask

  initial begin
    int       n;
    int       roll;
    int       enq_pct;
    int       deq_pct;
    pmeq_in_t w;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    issue(CMD_ENQ,   8'h00, PRIO_LOW,      1'b0, 1'b0);
    issue(CMD_ENQ,   8'hFF, PRIO_SYNC,     1'b1, 1'b1);
    issue(CMD_ENQ,   8'hA5, PRIO_NORMAL,   1'b0, 1'b0);
    issue(CMD_ENQ,   8'h5A, PRIO_CRITICAL, 1'b0, 1'b0);
    issue(CMD_NOP,   8'hFF, PRIO_SYNC,     1'b1, 1'b1);
    issue(CMD_DEQ,   8'h00, PRIO_LOW,      1'b1, 1'b0);
    issue(CMD_DEQ,   8'h00, PRIO_LOW,      1'b0, 1'b0);
    issue(CMD_DEQ,   8'h00, PRIO_LOW,      1'b0, 1'b0);
    issue(CMD_PURGE, 8'hFF, PRIO_SYNC,     1'b0, 1'b0);
    for (n = 0; n < 15; n++) begin
      issue(CMD_ENQ, (n % 3 == 0) ? 8'h3C : 8'(n),
            prio_e'((n % 3 == 0) ? PRIO_CRITICAL : PRIO_NORMAL), 1'b0, 1'b0);
    end
    issue(CMD_PURGE, 8'h3C, PRIO_SYNC,     1'b0, 1'b0);
    issue(CMD_PURGE, 8'h3C, PRIO_CRITICAL, 1'b0, 1'b0);

    enq_pct = 45;
    deq_pct = 35;
    for (n = 0; n < 450; n++) begin
      if (n % 30 == 0) begin
        steady_run = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 2))
          0: begin enq_pct = 65; deq_pct = 20; end
          1: begin enq_pct = 25; deq_pct = 55; end
          default: begin enq_pct = 45; deq_pct = 35; end
        endcase
      end
      roll = $urandom_range(0, 99);
      if (roll < enq_pct) w.cmd = CMD_ENQ;
      else if (roll < enq_pct + deq_pct) w.cmd = CMD_DEQ;
      else if (roll < 95) w.cmd = CMD_PURGE;
      else w.cmd = CMD_NOP;
      w.event_code    = ($urandom_range(0, 9) < 7) ? code_pool[$urandom_range(0, 3)]
                                                   : 8'($urandom);
      w.event_prio    = 2'($urandom);
      w.critical_only = 1'($urandom);
      w.low_ok        = 1'($urandom);
      send_word(w);
    end
    in_valid_i <= 1'b0;

    while (tracker.expected_words.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (tracker.failures == 0 && tracker.expected_words.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    int hold;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      hold = steady_run ? 0 : $urandom_range(0, 5);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      tracker.check_word(out_data_o);
    end
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== priority_masked_event_queue.f =====
design/pmeq_pkg.sv
design/pmeq_ram.sv
design/pmeq_ctrl.sv
design/priority_masked_event_queue.sv
dv/priority_masked_event_queue_test.sv
